// ===== hdl/sst_pkg.sv =====
// Package with the shared constants and payload types of the station signal tracker.
`timescale 1ns / 1ps
package sst_pkg;

  localparam int TABLE_DEPTH = 64;
  localparam int WINDOW      = 8;
  localparam int MAC_W       = 48;
  localparam int LEVEL_W     = 8;

  localparam int IDX_W       = $clog2(TABLE_DEPTH);
  localparam int CNT_W       = $clog2(TABLE_DEPTH + 1);
  localparam int PTR_W       = $clog2(WINDOW);
  localparam int FILL_W      = $clog2(WINDOW + 1);
  localparam int SUM_W       = $clog2(WINDOW * ((1 << LEVEL_W) - 1) + 1);
  localparam int WIN_DEPTH   = TABLE_DEPTH * (1 << PTR_W);

  typedef struct packed {
    logic [MAC_W-1:0]   mac_addr;
    logic [LEVEL_W-1:0] signal_level;
  } sst_in_t;

  typedef struct packed {
    logic               accepted;
    logic               new_entry;
    logic [5:0]         entry_index;
    logic [LEVEL_W-1:0] average_level;
    logic [3:0]         samples_held;
  } sst_out_t;

  typedef struct packed {
    logic [FILL_W-1:0]  fill;
    logic [LEVEL_W-1:0] avg;
    logic [SUM_W-1:0]   sum;
    logic [PTR_W-1:0]   wptr;
  } sst_meta_t;

  typedef struct packed {
    logic             start;
    logic [SUM_W-1:0] dividend;
    logic [FILL_W-1:0] divisor;
  } sst_div_req_t;

endpackage

// ===== hdl/sst_ram.sv =====
// Generic single-port-write, single-port-read RAM with registered read data.
`timescale 1ns / 1ps
module sst_ram #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 64
) (
  input  logic                     clk_i,
  input  logic                     we_i,
  input  logic [$clog2(DEPTH)-1:0] waddr_i,
  input  logic [WIDTH-1:0]         wdata_i,
  input  logic [$clog2(DEPTH)-1:0] raddr_i,
  output logic [WIDTH-1:0]         rdata_o
);

  logic [WIDTH-1:0] mem_q [DEPTH];
  logic [WIDTH-1:0] rdata_q;

  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem_q[waddr_i] <= wdata_i;
    end
    rdata_q <= mem_q[raddr_i];
  end

  assign rdata_o = rdata_q;

endmodule

// ===== hdl/sst_div.sv =====
// Restoring divider that produces one quotient bit per cycle.
`timescale 1ns / 1ps
module sst_div (
  input  logic                           clk_i,
  input  logic                           rst_ni,
  input  sst_pkg::sst_div_req_t          req_i,
  output logic                           done_o,
  output logic [sst_pkg::SUM_W-1:0]      quotient_o
);

  localparam int STEP_W = $clog2(sst_pkg::SUM_W + 1);

  logic                        busy_q, busy_d;
  logic                        done_q, done_d;
  logic [STEP_W-1:0]           cnt_q, cnt_d;
  logic [sst_pkg::FILL_W-1:0]  rem_q, rem_d;
  logic [sst_pkg::FILL_W-1:0]  dvs_q, dvs_d;
  logic [sst_pkg::SUM_W-1:0]   quo_q, quo_d;
  logic [sst_pkg::FILL_W:0]    trial;
  logic                        ge;

  always_comb begin
    trial  = {rem_q, quo_q[sst_pkg::SUM_W-1]};
    ge     = trial >= {1'b0, dvs_q};
    busy_d = busy_q;
    done_d = 1'b0;
    cnt_d  = cnt_q;
    rem_d  = rem_q;
    dvs_d  = dvs_q;
    quo_d  = quo_q;
    if (req_i.start) begin
      busy_d = 1'b1;
      cnt_d  = STEP_W'(sst_pkg::SUM_W);
      rem_d  = '0;
      dvs_d  = req_i.divisor;
      quo_d  = req_i.dividend;
    end else if (busy_q) begin
      rem_d = ge ? sst_pkg::FILL_W'(trial - {1'b0, dvs_q}) : sst_pkg::FILL_W'(trial);
      quo_d = {quo_q[sst_pkg::SUM_W-2:0], ge};
      cnt_d = cnt_q - 1'b1;
      if (cnt_q == STEP_W'(1)) begin
        busy_d = 1'b0;
        done_d = 1'b1;
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      busy_q <= 1'b0;
      done_q <= 1'b0;
      cnt_q  <= '0;
    end else begin
      busy_q <= busy_d;
      done_q <= done_d;
      cnt_q  <= cnt_d;
    end
  end

  always_ff @(posedge clk_i) begin
    rem_q <= rem_d;
    dvs_q <= dvs_d;
    quo_q <= quo_d;
  end

  assign done_o     = done_q;
  assign quotient_o = quo_q;

endmodule

// ===== hdl/station_signal_tracker_core.sv =====
// Top level of the station signal tracker: search sequencer, tables and averaging datapath.
`timescale 1ns / 1ps
// Usage: a transaction is offered on req_i with start high and is taken at a clock edge at
// which busy is low. Each transaction carries a 48-bit station address and a signal level.
// The block searches its address table one entry per cycle, takes the matching entry or the
// next free one, updates that entry's sample window and average, and then presents one
// result on res_o for a single cycle with done_o high. The receiver cannot stall, so the
// result must be captured in that cycle.
// From the accepting edge the block runs the address search, then for an existing entry
// the meta read states ST_META and ST_LOAD, then ST_CALC and the bit-serial division in
// ST_DIV before the result strobe; a rejection ends the search once all 64 entries have
// been examined. The address search through the address RAM and the bit-serial divider
// take up most of a transaction's time.
// busy stays high for the whole transaction, so one transaction is worked on at a time.
// A transaction that finds no match in a full table is rejected with an all-zero result.
// Reset empties the table at once through the entry count; no clearing pass is needed,
// and the block can accept a transaction in the first cycle after reset.
module station_signal_tracker_core (
  input  logic               clk_i,
  input  logic               rst_ni,
  input  logic               start,
  output logic               busy,
  input  sst_pkg::sst_in_t   req_i,
  output logic               done_o,
  output sst_pkg::sst_out_t  res_o
);

  typedef enum logic [2:0] {
    ST_IDLE,
    ST_SEARCH,
    ST_META,
    ST_LOAD,
    ST_CALC,
    ST_DIV
  } state_e;

  state_e                         state_q, state_d;
  logic [sst_pkg::CNT_W-1:0]      used_q, used_d;
  logic                           done_q, done_d;
  sst_pkg::sst_out_t              res_q, res_d;

  logic [sst_pkg::MAC_W-1:0]      mac_q, mac_d;
  logic [sst_pkg::LEVEL_W-1:0]    level_q, level_d;
  logic [sst_pkg::IDX_W-1:0]      idx_q, idx_d;
  logic [sst_pkg::IDX_W-1:0]      e_q, e_d;
  logic                           fresh_q, fresh_d;
  sst_pkg::sst_meta_t             meta_q, meta_d;
  sst_pkg::sst_meta_t             new_meta_q, new_meta_d;
  sst_pkg::sst_meta_t             meta_wr;

  logic                           mac_we;
  logic [sst_pkg::IDX_W-1:0]      mac_raddr;
  logic [sst_pkg::MAC_W-1:0]      mac_rdata;
  logic                           meta_we;
  sst_pkg::sst_meta_t             meta_rdata;
  logic                           win_we;
  logic [sst_pkg::IDX_W+sst_pkg::PTR_W-1:0] win_raddr, win_waddr;
  logic [sst_pkg::LEVEL_W-1:0]    win_rdata;

  sst_pkg::sst_div_req_t          div_req;
  logic                           div_done;
  logic [sst_pkg::SUM_W-1:0]      div_quo;

  logic [sst_pkg::LEVEL_W+sst_pkg::FILL_W-1:0] prod;
  logic                           filling;

  assign mac_raddr = (state_q == ST_IDLE) ? '0 : sst_pkg::IDX_W'(idx_q + 1'b1);
  assign win_raddr = {e_q, meta_rdata.wptr};
  assign win_waddr = {e_q, meta_q.wptr};

  sst_ram #(
    .WIDTH(sst_pkg::MAC_W),
    .DEPTH(sst_pkg::TABLE_DEPTH)
  ) u_mac_ram (
    .clk_i  (clk_i),
    .we_i   (mac_we),
    .waddr_i(sst_pkg::IDX_W'(used_q)),
    .wdata_i(mac_q),
    .raddr_i(mac_raddr),
    .rdata_o(mac_rdata)
  );

  sst_ram #(
    .WIDTH($bits(sst_pkg::sst_meta_t)),
    .DEPTH(sst_pkg::TABLE_DEPTH)
  ) u_meta_ram (
    .clk_i  (clk_i),
    .we_i   (meta_we),
    .waddr_i(e_q),
    .wdata_i(meta_wr),
    .raddr_i(e_q),
    .rdata_o(meta_rdata)
  );

  sst_ram #(
    .WIDTH(sst_pkg::LEVEL_W),
    .DEPTH(sst_pkg::WIN_DEPTH)
  ) u_win_ram (
    .clk_i  (clk_i),
    .we_i   (win_we),
    .waddr_i(win_waddr),
    .wdata_i(level_q),
    .raddr_i(win_raddr),
    .rdata_o(win_rdata)
  );

  sst_div u_div (
    .clk_i     (clk_i),
    .rst_ni    (rst_ni),
    .req_i     (div_req),
    .done_o    (div_done),
    .quotient_o(div_quo)
  );

  always_comb begin
    state_d    = state_q;
    used_d     = used_q;
    done_d     = 1'b0;
    res_d      = res_q;
    mac_d      = mac_q;
    level_d    = level_q;
    idx_d      = idx_q;
    e_d        = e_q;
    fresh_d    = fresh_q;
    meta_d     = meta_q;
    new_meta_d = new_meta_q;
    mac_we     = 1'b0;
    meta_we    = 1'b0;
    win_we     = 1'b0;
    div_req    = '0;
    filling    = meta_q.fill < sst_pkg::FILL_W'(sst_pkg::WINDOW);
    prod       = meta_q.avg * meta_q.fill;

    case (state_q)
      ST_IDLE: begin
        if (start) begin
          mac_d   = req_i.mac_addr;
          level_d = req_i.signal_level;
          idx_d   = '0;
          state_d = ST_SEARCH;
        end
      end
      ST_SEARCH: begin
        if (used_q != '0 && mac_rdata == mac_q) begin
          e_d     = idx_q;
          fresh_d = 1'b0;
          state_d = ST_META;
        end else if ((sst_pkg::CNT_W'(idx_q) + 1'b1) >= used_q) begin
          if (used_q == sst_pkg::CNT_W'(sst_pkg::TABLE_DEPTH)) begin
            res_d   = '0;
            done_d  = 1'b1;
            state_d = ST_IDLE;
          end else begin
            mac_we  = 1'b1;
            e_d     = sst_pkg::IDX_W'(used_q);
            used_d  = used_q + 1'b1;
            fresh_d = 1'b1;
            meta_d  = '0;
            state_d = ST_CALC;
          end
        end else begin
          idx_d = idx_q + 1'b1;
        end
      end
      ST_META: begin
        state_d = ST_LOAD;
      end
      ST_LOAD: begin
        meta_d  = meta_rdata;
        state_d = ST_CALC;
      end
      ST_CALC: begin
        div_req.start = 1'b1;
        if (filling) begin
          div_req.dividend = sst_pkg::SUM_W'(prod) + sst_pkg::SUM_W'(level_q);
          div_req.divisor  = meta_q.fill + 1'b1;
          new_meta_d.sum   = meta_q.sum + sst_pkg::SUM_W'(level_q);
          new_meta_d.fill  = meta_q.fill + 1'b1;
        end else begin
          new_meta_d.sum   = meta_q.sum - sst_pkg::SUM_W'(win_rdata)
                             + sst_pkg::SUM_W'(level_q);
          div_req.dividend = new_meta_d.sum;
          div_req.divisor  = sst_pkg::FILL_W'(sst_pkg::WINDOW);
          new_meta_d.fill  = sst_pkg::FILL_W'(sst_pkg::WINDOW);
        end
        new_meta_d.wptr = (meta_q.wptr == sst_pkg::PTR_W'(sst_pkg::WINDOW - 1)) ?
                          '0 : meta_q.wptr + 1'b1;
        new_meta_d.avg  = '0;
        state_d         = ST_DIV;
      end
      ST_DIV: begin
        new_meta_d.avg = div_quo[sst_pkg::LEVEL_W-1:0];
        if (div_done) begin
          meta_we             = 1'b1;
          win_we              = 1'b1;
          res_d.accepted      = 1'b1;
          res_d.new_entry     = fresh_q;
          res_d.entry_index   = 6'(e_q);
          res_d.average_level = div_quo[sst_pkg::LEVEL_W-1:0];
          res_d.samples_held  = 4'(new_meta_q.fill);
          done_d              = 1'b1;
          state_d             = ST_IDLE;
        end
      end
      default: begin
        state_d = ST_IDLE;
      end
    endcase
  end

  // The meta RAM is written with the quotient in the same cycle as the divider finishes.
  always_comb begin
    meta_wr     = new_meta_q;
    meta_wr.avg = div_quo[sst_pkg::LEVEL_W-1:0];
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= ST_IDLE;
      used_q  <= '0;
      done_q  <= 1'b0;
    end else begin
      state_q <= state_d;
      used_q  <= used_d;
      done_q  <= done_d;
    end
  end

  always_ff @(posedge clk_i) begin
    res_q      <= res_d;
    mac_q      <= mac_d;
    level_q    <= level_d;
    idx_q      <= idx_d;
    e_q        <= e_d;
    fresh_q    <= fresh_d;
    meta_q     <= meta_d;
    new_meta_q <= (state_q == ST_DIV) ? new_meta_q : new_meta_d;
  end

  assign busy   = (state_q != ST_IDLE);
  assign done_o = done_q;
  assign res_o  = res_q;

  a_used_bound: assert property (@(posedge clk_i) disable iff (!rst_ni)
    used_q <= sst_pkg::CNT_W'(sst_pkg::TABLE_DEPTH))
    else $error("entry count beyond table depth");

  a_reject_full: assert property (@(posedge clk_i) disable iff (!rst_ni)
    done_o && !res_o.accepted |-> used_q == sst_pkg::CNT_W'(sst_pkg::TABLE_DEPTH))
    else $error("transaction rejected while the table had room");

  a_new_counts: assert property (@(posedge clk_i) disable iff (!rst_ni)
    mac_we |=> used_q == $past(used_q) + 1'b1)
    else $error("entry taken without advancing the entry count");

  a_done_idle: assert property (@(posedge clk_i) disable iff (!rst_ni)
    done_o |-> !busy)
    else $error("result strobe while still busy");

  a_div_seq: assert property (@(posedge clk_i) disable iff (!rst_ni)
    div_done |-> state_q == ST_DIV)
    else $error("divider finished outside the division step");

endmodule
